>>> hdl/csu_pkg.sv
// Package for the context statistics update block: sizes, codes and the
// packed record of one context as it is kept in the statistics RAM.
// No dependencies.
`default_nettype none

package csu_pkg;

    localparam int NUM_CONTEXTS = 365;
    localparam int ADDR_W       = $clog2(NUM_CONTEXTS);

    localparam int CTX_W   = 9;
    localparam int ERR_W   = 16;
    localparam int A_W     = 32;
    localparam int B_W     = 18;
    localparam int BOUT_W  = 17;
    localparam int C_W     = 8;
    localparam int N_W     = 16;
    localparam int NEAR_W  = 8;
    localparam int AINIT_W = 11;
    localparam int CFG_W   = 16;
    localparam int CFGI_W  = 2;

    // Scaled error: ERR_W signed times a (NEAR_W+2)-bit positive factor.
    localparam int PROD_W  = ERR_W + NEAR_W + 2;
    // Bias sum before halving, and the working width of the bias step.
    localparam int BSUM_W  = PROD_W;
    localparam int BADJ_W  = BSUM_W + 1;

    localparam logic [0:0] OP_UPDATE = 1'b0;
    localparam logic [0:0] OP_CLEAR  = 1'b1;

    localparam logic [CFGI_W-1:0] CFG_NEAR      = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_A_INIT    = 2'd2;

    localparam logic [NEAR_W-1:0]  NEAR_RESET      = 8'd0;
    localparam logic [N_W-1:0]     THRESHOLD_RESET = 16'd64;
    localparam logic [AINIT_W-1:0] A_INIT_RESET    = 11'd4;

    localparam logic signed [C_W-1:0] C_MAX = 8'sd127;
    localparam logic signed [C_W-1:0] C_MIN = -8'sd128;

    typedef struct packed {
        logic        [A_W-1:0] a;
        logic signed [B_W-1:0] b;
        logic signed [C_W-1:0] c;
        logic        [N_W-1:0] n;
    } t_ctx_stats;

    localparam int STATS_W = $bits(t_ctx_stats);

    // Operands of one update that do not come from the table.
    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic        [ERR_W-1:0]  err_abs;
    } t_upd_op;

endpackage

`default_nettype wire

>>> hdl/context_statistics_update.sv
// Top level of the context statistics update block: control sequencer,
// configuration registers, result register. Depends on csu_pkg, csu_ram
// and csu_update.
//
// Usage
//   Request channel: drive i_operation, i_context_req and i_error_value with
//   start high; the request is taken at a rising edge where busy is low.
//   An update request returns its result after the read, the accumulate and
//   halve, and the bias step with write-back; busy stays high until the
//   write-back, so a new update is not taken before the last one is written
//   back, as the read-modify-write of the single statistics RAM requires.
//   A clear request rewrites every context, one RAM row a cycle, so busy
//   stays high until all NUM_CONTEXTS (365) rows are written, and the result
//   follows the last row write.
//   Result channel: o_valid is high for exactly one cycle with the result
//   fields; the receiver cannot stall and must take it then.
//   An update for a context index beyond the table leaves the state alone
//   and returns the index with all other fields zero.
//   Configuration: write i_cfg_data to register i_cfg_index with i_cfg_we;
//   0 near, 1 reset threshold, 2 initial A. Write only while idle.
//   Reset: synchronous, active low. After reset a clearing pass over all 365
//   rows fills the table with the reset initial values; busy is high and
//   no result is given. Configuration writes are taken during that pass.
`default_nettype none

module context_statistics_update (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire  [0:0]                           i_operation,
    input  wire  [csu_pkg::CTX_W-1:0]            i_context_req,
    input  wire  signed [csu_pkg::ERR_W-1:0]     i_error_value,
    input  wire                                  i_cfg_we,
    input  wire  [csu_pkg::CFGI_W-1:0]           i_cfg_index,
    input  wire  [csu_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                 o_valid,
    output logic [csu_pkg::CTX_W-1:0]            o_context_out,
    output logic [csu_pkg::A_W-1:0]              o_accum_a,
    output logic signed [csu_pkg::BOUT_W-1:0]    o_bias_b,
    output logic signed [csu_pkg::C_W-1:0]       o_correction_c,
    output logic [csu_pkg::N_W-1:0]              o_count_n
);
    import csu_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;
    localparam logic [1:0] ST_CLR  = 2'd3;

    // Configuration registers.
    logic [NEAR_W-1:0]  r_near;
    logic [N_W-1:0]     r_threshold;
    logic [AINIT_W-1:0] r_a_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near      <= NEAR_RESET;
            r_threshold <= THRESHOLD_RESET;
            r_a_init    <= A_INIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NEAR:      r_near      <= i_cfg_data[NEAR_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[N_W-1:0];
                CFG_A_INIT:    r_a_init    <= i_cfg_data[AINIT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Sequencer state.
    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [ADDR_W-1:0] r_sweep;
    logic              r_sweep_reset;   // clearing pass after reset: no result
    logic [CTX_W-1:0]  r_ctx;
    logic              r_oob;
    t_upd_op           r_op;

    logic accept;
    logic req_oob;
    logic sweep_last;
    logic [ERR_W-1:0] err_abs;
    logic signed [PROD_W-1:0] prod;

    assign busy       = (r_state != ST_IDLE);
    assign accept     = start && !busy;
    assign req_oob    = (int'(i_context_req) >= NUM_CONTEXTS);
    assign sweep_last = (r_sweep == ADDR_W'(NUM_CONTEXTS - 1));

    // Scale the error by 2*near+1; take its magnitude (the most negative
    // error maps onto its unsigned magnitude).
    assign err_abs = i_error_value[ERR_W-1] ? ERR_W'(-i_error_value) : i_error_value;
    assign prod    = PROD_W'(i_error_value * $signed({1'b0, r_near, 1'b1}));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_operation == OP_CLEAR) ? ST_CLR : ST_READ;
                end
            end
            ST_READ: n_state = ST_WB;
            ST_WB:   n_state = ST_IDLE;
            ST_CLR:  n_state = sweep_last ? ST_IDLE : ST_CLR;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLR;
            r_sweep       <= '0;
            r_sweep_reset <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) begin
                r_sweep <= sweep_last ? '0 : r_sweep + ADDR_W'(1);
            end
            if (accept) begin
                r_sweep_reset <= 1'b0;
            end
        end
    end

    // Hold the request payload for the duration of the update.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctx        <= i_context_req;
            r_oob        <= req_oob;
            r_op.prod    <= prod;
            r_op.err_abs <= err_abs;
        end
    end

    // Statistics RAM and update datapath.
    t_ctx_stats       rd_stats;
    t_ctx_stats       upd_stats;
    t_ctx_stats       init_stats;
    logic [STATS_W-1:0] ram_rdata;
    logic [STATS_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_waddr;
    logic               ram_we;
    logic               ram_re;

    always_comb begin
        init_stats.a = A_W'(r_sweep_reset ? A_INIT_RESET : r_a_init);
        init_stats.b = '0;
        init_stats.c = '0;
        init_stats.n = N_W'(1);
    end

    assign ram_re    = accept && (i_operation == OP_UPDATE) && !req_oob;
    assign ram_we    = (r_state == ST_CLR) || ((r_state == ST_WB) && !r_oob);
    assign ram_waddr = (r_state == ST_CLR) ? r_sweep : ADDR_W'(r_ctx);
    assign ram_wdata = (r_state == ST_CLR) ? init_stats : upd_stats;
    assign rd_stats  = ram_rdata;

    csu_ram #(
        .WIDTH (STATS_W),
        .DEPTH (NUM_CONTEXTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ADDR_W'(i_context_req)),
        .o_rdata (ram_rdata)
    );

    csu_update u_update (
        .i_clk       (i_clk),
        .i_load      (r_state == ST_READ),
        .i_stats     (rd_stats),
        .i_op        (r_op),
        .i_threshold (r_threshold),
        .o_stats     (upd_stats)
    );

    // Result register: one strobe per request, none for the reset pass.
    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_WB) ||
                       ((r_state == ST_CLR) && sweep_last && !r_sweep_reset);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WB) begin
            o_context_out <= r_ctx;
            if (r_oob) begin
                o_accum_a      <= '0;
                o_bias_b       <= '0;
                o_correction_c <= '0;
                o_count_n      <= '0;
            end else begin
                o_accum_a      <= upd_stats.a;
                o_bias_b       <= BOUT_W'(upd_stats.b);
                o_correction_c <= upd_stats.c;
                o_count_n      <= upd_stats.n;
            end
        end else if (r_state == ST_CLR) begin
            o_context_out  <= '0;
            o_accum_a      <= A_W'(r_a_init);
            o_bias_b       <= '0;
            o_correction_c <= '0;
            o_count_n      <= N_W'(1);
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

>>> hdl/csu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module csu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/csu_update.sv
// Two-stage arithmetic of one context update: accumulate, halve, bias step.
// Depends on csu_pkg.
`default_nettype none

module csu_update (
    input  wire                          i_clk,
    input  wire                          i_load,
    input  wire csu_pkg::t_ctx_stats     i_stats,
    input  wire csu_pkg::t_upd_op        i_op,
    input  wire  [csu_pkg::N_W-1:0]      i_threshold,
    output csu_pkg::t_ctx_stats          o_stats
);
    import csu_pkg::*;

    // Stage 1: accumulate and halve.
    logic        [A_W:0]      a_sum;
    logic        [A_W-1:0]    a_sat;
    logic signed [BSUM_W-1:0] b_sum;
    logic                     halve;
    logic        [A_W-1:0]    n_a;
    logic signed [BSUM_W-1:0] n_b;
    logic        [N_W-1:0]    n_n;

    logic        [A_W-1:0]    r_a;
    logic signed [BSUM_W-1:0] r_b;
    logic signed [C_W-1:0]    r_c;
    logic        [N_W-1:0]    r_n;

    always_comb begin
        a_sum = {1'b0, i_stats.a} + (A_W+1)'(i_op.err_abs);
        a_sat = a_sum[A_W] ? {A_W{1'b1}} : a_sum[A_W-1:0];
        b_sum = BSUM_W'(i_stats.b) + BSUM_W'(i_op.prod);
        halve = (i_stats.n >= i_threshold);
        n_a   = halve ? (a_sat >> 1) : a_sat;
        n_b   = halve ? (b_sum >>> 1) : b_sum;
        n_n   = (halve ? (i_stats.n >> 1) : i_stats.n) + N_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= i_stats.c;
            r_n <= n_n;
        end
    end

    // Stage 2: pull B back into -N+1..0 and step C.
    logic signed [BADJ_W-1:0] nn;
    logic signed [BADJ_W-1:0] bw;
    logic signed [BADJ_W-1:0] t;
    logic signed [BADJ_W-1:0] b_new;
    logic signed [C_W-1:0]    c_new;

    always_comb begin
        nn    = $signed({{(BADJ_W-N_W){1'b0}}, r_n});
        bw    = BADJ_W'(r_b);
        t     = bw;
        b_new = bw;
        c_new = r_c;
        priority if (bw <= -nn) begin
            t     = bw + nn;
            c_new = (r_c > C_MIN) ? r_c - C_W'(1) : r_c;
            b_new = (t <= -nn) ? (BADJ_W'(1) - nn) : t;
        end else if (bw > 0) begin
            t     = bw - nn;
            c_new = (r_c < C_MAX) ? r_c + C_W'(1) : r_c;
            b_new = (t > 0) ? '0 : t;
        end else begin
            b_new = bw;
        end
    end

    always_comb begin
        o_stats.a = r_a;
        o_stats.b = B_W'(b_new);
        o_stats.c = c_new;
        o_stats.n = r_n;
    end

endmodule

`default_nettype wire
